### rtl/dmp_pkg.sv
// ============================================================================
// DMP integrator package
// Shared widths, codes, control types and fixed-point helpers for the
// three-axis trajectory integrator.
// ============================================================================
package dmp_pkg;

  localparam int DATA_W    = 32;   // Q16.16 words
  localparam int PHASE_W   = 17;   // unsigned Q1.16, 65536 is one
  localparam int FRAC_W    = 16;
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 33;   // multiplier operand magnitude
  localparam int PROD_W    = 2 * OP_W;
  localparam int QUOT_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = 52;   // exact acceleration sum

  localparam int unsigned DT_Q16_DEFAULT = 655;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_GOAL_Z,
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_GAIN_P,
    REG_GAIN_V
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_DONE
  } fsm_t;

  // micro-steps of one axis; each issues a product, consumes the last one, or both
  typedef enum logic [3:0] {
    STEP_T1_ISS,    // issue |forcing| * |goal - start|
    STEP_TP_ISS,    // issue gain_p * |goal - pos|, take forcing product
    STEP_TFL_ISS,   // issue phase * low word, take stiffness term
    STEP_TFH_ISS,   // issue phase * high word, take low phase product
    STEP_TV_ISS,    // issue gain_v * |vel|, add forcing term
    STEP_ACC,       // subtract damping term, clamp acceleration
    STEP_VEL_ISS,   // issue |acc| * dt
    STEP_VEL_UPD,   // update velocity
    STEP_POS_ISS,   // issue |vel| * dt
    STEP_POS_UPD    // update position
  } step_t;

  typedef struct packed {
    logic              in_ready;
    logic              run;
    logic              load_out;
    logic [AXIS_W-1:0] axis;
    step_t             step;
  } seq_ctl_t;

  // magnitude of a 33-bit signed value (never the most negative code here)
  function automatic logic [OP_W-1:0] mag33(input logic signed [OP_W-1:0] v);
    logic signed [OP_W-1:0] n;
    n = -v;
    return v[OP_W-1] ? OP_W'(n) : OP_W'(v);
  endfunction

  // reapply a sign to a truncated product magnitude
  function automatic logic signed [SUM_W-1:0] apply_sign(input logic neg,
                                                         input logic [QUOT_W-1:0] m);
    logic signed [SUM_W-1:0] ext;
    ext = signed'(SUM_W'(m));
    return neg ? -ext : ext;
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = 52'sd2147483647;
    lo = -hi - 52'sd1;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### rtl/dmp_if.sv
// ============================================================================
// DMP integrator channels
// Valid/ready channels for step requests and position results.
// ============================================================================
interface dmp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               restart;
  logic        [dmp_pkg::PHASE_W-1:0] phase;
  logic signed [dmp_pkg::DATA_W-1:0]  forcing_x;
  logic signed [dmp_pkg::DATA_W-1:0]  forcing_y;
  logic signed [dmp_pkg::DATA_W-1:0]  forcing_z;

  modport source (output valid, restart, phase, forcing_x, forcing_y, forcing_z,
                  input ready);
  modport sink   (input valid, restart, phase, forcing_x, forcing_y, forcing_z,
                  output ready);
endinterface

interface dmp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dmp_pkg::DATA_W-1:0] pos_x;
  logic signed [dmp_pkg::DATA_W-1:0] pos_y;
  logic signed [dmp_pkg::DATA_W-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/dmp_mul.sv
// ============================================================================
// DMP shared multiplier
// Unsigned magnitude multiplier with a registered product.
// ============================================================================
module dmp_mul #(
  parameter int A_W = dmp_pkg::OP_W,
  parameter int B_W = dmp_pkg::OP_W
) (
  input  logic             clk,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] prod_r
);

  logic [A_W+B_W-1:0] prod_nxt;

  assign prod_nxt = (A_W+B_W)'(a) * (A_W+B_W)'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/dmp_seq.sv
// ============================================================================
// DMP step sequencer
// Walks the micro-steps of each axis and hands the result to the output stage.
// ============================================================================
module dmp_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  output dmp_pkg::seq_ctl_t ctl
);

  localparam logic [dmp_pkg::AXIS_W-1:0] AXIS_LAST =
    dmp_pkg::AXIS_W'(dmp_pkg::NUM_AXES - 1);

  dmp_pkg::fsm_t                state_r, state_nxt;
  dmp_pkg::step_t               step_r, step_nxt;
  logic [dmp_pkg::AXIS_W-1:0]   axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmp_pkg::FSM_IDLE;
      step_r  <= dmp_pkg::STEP_T1_ISS;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    axis_nxt     = axis_r;
    ctl.in_ready = 1'b0;
    ctl.run      = 1'b0;
    ctl.load_out = 1'b0;
    ctl.axis     = axis_r;
    ctl.step     = step_r;
    case (state_r)
      dmp_pkg::FSM_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_fire) begin
          state_nxt = dmp_pkg::FSM_RUN;
          step_nxt  = dmp_pkg::STEP_T1_ISS;
          axis_nxt  = '0;
        end
      end
      dmp_pkg::FSM_RUN: begin
        ctl.run = 1'b1;
        case (step_r)
          dmp_pkg::STEP_T1_ISS:  step_nxt = dmp_pkg::STEP_TP_ISS;
          dmp_pkg::STEP_TP_ISS:  step_nxt = dmp_pkg::STEP_TFL_ISS;
          dmp_pkg::STEP_TFL_ISS: step_nxt = dmp_pkg::STEP_TFH_ISS;
          dmp_pkg::STEP_TFH_ISS: step_nxt = dmp_pkg::STEP_TV_ISS;
          dmp_pkg::STEP_TV_ISS:  step_nxt = dmp_pkg::STEP_ACC;
          dmp_pkg::STEP_ACC:     step_nxt = dmp_pkg::STEP_VEL_ISS;
          dmp_pkg::STEP_VEL_ISS: step_nxt = dmp_pkg::STEP_VEL_UPD;
          dmp_pkg::STEP_VEL_UPD: step_nxt = dmp_pkg::STEP_POS_ISS;
          dmp_pkg::STEP_POS_ISS: step_nxt = dmp_pkg::STEP_POS_UPD;
          dmp_pkg::STEP_POS_UPD: begin
            // advance to the next axis, or finish the step
            step_nxt = dmp_pkg::STEP_T1_ISS;
            if (axis_r == AXIS_LAST) begin
              state_nxt = dmp_pkg::FSM_DONE;
            end else begin
              axis_nxt = axis_r + 1'b1;
            end
          end
          default: step_nxt = dmp_pkg::STEP_T1_ISS;
        endcase
      end
      dmp_pkg::FSM_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = dmp_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = dmp_pkg::FSM_IDLE;
    endcase
  end

endmodule

### rtl/dmp_trajectory_integrator_top.sv
// ============================================================================
// DMP trajectory integrator, top level
// Three-axis dynamic movement primitive integrator in Q16.16 fixed point with
// one shared multiplier under a micro-step sequencer.
// ============================================================================
//
//   channel   direction  handshake      content
//   in_ch     in         valid/ready    restart, phase, forcing_x/y/z
//   out_ch    out        valid/ready    pos_x/y/z after the step
//   cfg_*     in         write enable   goal, start, gain_p, gain_v
//
// After acceptance a request runs ten micro-steps per axis on the one 33x33
// multiplier, three axes in turn, then loads the output register once it is free and
// returns to idle, where the next request can be accepted.
// Reset (rst_n low, synchronous) clears goal, start, gains, position and velocity.
// A result that is not taken holds in the output register while the next request
// is computed; only loading that next result waits on out_ch.ready.
//
module dmp_trajectory_integrator_top #(
  parameter int unsigned DT_Q16 = dmp_pkg::DT_Q16_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dmp_in_if.sink                            in_ch,
  dmp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [dmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmp_pkg::DATA_W-1:0]        cfg_wdata
);

  localparam int DW      = dmp_pkg::DATA_W;
  localparam int OW      = dmp_pkg::OP_W;
  localparam int PW      = dmp_pkg::PROD_W;
  localparam int FW      = dmp_pkg::FRAC_W;
  localparam int QW      = dmp_pkg::QUOT_W;
  localparam int SW      = dmp_pkg::SUM_W;
  localparam int NA      = dmp_pkg::NUM_AXES;
  // |forcing| * |goal - start| / 2^16 stays below 2^47
  localparam int T1_W    = 47;
  localparam int T1_LO_W = 32;
  // phase * low word / 2^16 stays below 2^33
  localparam int TFL_W   = 33;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] goal_r  [NA];
  logic signed [DW-1:0] start_r [NA];
  logic        [DW-1:0] gain_p_r;
  logic        [DW-1:0] gain_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        goal_r[i]  <= '0;
        start_r[i] <= '0;
      end
      gain_p_r <= '0;
      gain_v_r <= '0;
    end else if (cfg_we) begin
      case (dmp_pkg::cfg_reg_t'(cfg_index))
        dmp_pkg::REG_GOAL_X:  goal_r[0]  <= cfg_wdata;
        dmp_pkg::REG_GOAL_Y:  goal_r[1]  <= cfg_wdata;
        dmp_pkg::REG_GOAL_Z:  goal_r[2]  <= cfg_wdata;
        dmp_pkg::REG_START_X: start_r[0] <= cfg_wdata;
        dmp_pkg::REG_START_Y: start_r[1] <= cfg_wdata;
        dmp_pkg::REG_START_Z: start_r[2] <= cfg_wdata;
        dmp_pkg::REG_GAIN_P:  gain_p_r   <= cfg_wdata;
        dmp_pkg::REG_GAIN_V:  gain_v_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  dmp_pkg::seq_ctl_t ctl;
  logic              in_fire;
  logic              out_valid_r;
  logic              out_free;

  assign in_fire  = in_ch.valid && ctl.in_ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ctl.in_ready;

  dmp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // --------------------------------------------------------------------------
  // Request capture
  // --------------------------------------------------------------------------
  logic        [dmp_pkg::PHASE_W-1:0] phase_r;
  logic signed [DW-1:0]               forcing_r [NA];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      phase_r      <= in_ch.phase;
      forcing_r[0] <= in_ch.forcing_x;
      forcing_r[1] <= in_ch.forcing_y;
      forcing_r[2] <= in_ch.forcing_z;
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis operands
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] pos_r [NA];
  logic signed [DW-1:0] vel_r [NA];

  logic signed [DW-1:0] goal_a, start_a, pos_a, vel_a, frc_a;
  logic signed [OW-1:0] diff_gp, diff_gs;
  logic        [OW-1:0] gp_mag, gs_mag, frc_mag, vel_mag, acc_mag;

  logic                 t1_neg_r;
  logic        [T1_W-1:0]  t1_mag_r;
  logic        [TFL_W-1:0] tfl_r;
  logic signed [SW-1:0] sum_r;
  logic signed [DW-1:0] acc_r;

  assign goal_a  = goal_r[ctl.axis];
  assign start_a = start_r[ctl.axis];
  assign pos_a   = pos_r[ctl.axis];
  assign vel_a   = vel_r[ctl.axis];
  assign frc_a   = forcing_r[ctl.axis];

  // goal differences formed exactly in 33 bits
  assign diff_gp = OW'(goal_a) - OW'(pos_a);
  assign diff_gs = OW'(goal_a) - OW'(start_a);
  assign gp_mag  = dmp_pkg::mag33(diff_gp);
  assign gs_mag  = dmp_pkg::mag33(diff_gs);
  assign frc_mag = dmp_pkg::mag33(OW'(frc_a));
  assign vel_mag = dmp_pkg::mag33(OW'(vel_a));
  assign acc_mag = dmp_pkg::mag33(OW'(acc_r));

  // --------------------------------------------------------------------------
  // Shared multiplier: operands selected by the micro-step
  // --------------------------------------------------------------------------
  logic [OW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod_r;
  logic [QW-1:0] prod_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.step)
      dmp_pkg::STEP_T1_ISS: begin
        mul_a = frc_mag;
        mul_b = gs_mag;
      end
      dmp_pkg::STEP_TP_ISS: begin
        mul_a = OW'(gain_p_r);
        mul_b = gp_mag;
      end
      dmp_pkg::STEP_TFL_ISS: begin
        mul_a = OW'(phase_r);
        mul_b = OW'(t1_mag_r[T1_LO_W-1:0]);
      end
      dmp_pkg::STEP_TFH_ISS: begin
        mul_a = OW'(phase_r);
        mul_b = OW'(t1_mag_r[T1_W-1:T1_LO_W]);
      end
      dmp_pkg::STEP_TV_ISS: begin
        mul_a = OW'(gain_v_r);
        mul_b = vel_mag;
      end
      dmp_pkg::STEP_VEL_ISS: begin
        mul_a = acc_mag;
        mul_b = OW'(DT_Q16);
      end
      dmp_pkg::STEP_POS_ISS: begin
        mul_a = vel_mag;
        mul_b = OW'(DT_Q16);
      end
      default: ;
    endcase
  end

  dmp_mul #(
    .A_W (OW),
    .B_W (OW)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // every product is truncated toward zero: drop the fraction of the magnitude
  assign prod_q = prod_r[PW-1:FW];

  // --------------------------------------------------------------------------
  // Consume the previous product
  // --------------------------------------------------------------------------
  logic [QW-1:0] tf_mag;

  // phase * |t1| / 2^16 = (phase * high) << 16 + (phase * low) / 2^16, exactly
  assign tf_mag = QW'({prod_r[T1_LO_W-1:0], {FW{1'b0}}}) + QW'(tfl_r);

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      case (ctl.step)
        dmp_pkg::STEP_TP_ISS: begin
          t1_neg_r <= frc_a[DW-1];
          t1_mag_r <= prod_r[FW+T1_W-1:FW];
        end
        dmp_pkg::STEP_TFL_ISS: sum_r <= dmp_pkg::apply_sign(diff_gp[OW-1], prod_q);
        dmp_pkg::STEP_TFH_ISS: tfl_r <= prod_r[FW+TFL_W-1:FW];
        dmp_pkg::STEP_TV_ISS:  sum_r <= sum_r + dmp_pkg::apply_sign(t1_neg_r, tf_mag);
        dmp_pkg::STEP_ACC: begin
          acc_r <= dmp_pkg::sat32(sum_r - dmp_pkg::apply_sign(vel_a[DW-1], prod_q));
        end
        default: ;
      endcase
    end
  end

  // position and velocity state; restart reloads all axes at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else if (in_fire && in_ch.restart) begin
      for (int i = 0; i < NA; i++) begin
        pos_r[i] <= start_r[i];
        vel_r[i] <= '0;
      end
    end else if (ctl.run && ctl.step == dmp_pkg::STEP_VEL_UPD) begin
      vel_r[ctl.axis] <= dmp_pkg::sat32(SW'(vel_a) +
                                        dmp_pkg::apply_sign(acc_r[DW-1], prod_q));
    end else if (ctl.run && ctl.step == dmp_pkg::STEP_POS_UPD) begin
      pos_r[ctl.axis] <= dmp_pkg::sat32(SW'(pos_a) +
                                        dmp_pkg::apply_sign(vel_a[DW-1], prod_q));
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] out_pos_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      for (int i = 0; i < NA; i++) begin
        out_pos_r[i] <= pos_r[i];
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = out_pos_r[0];
  assign out_ch.pos_y = out_pos_r[1];
  assign out_ch.pos_z = out_pos_r[2];

endmodule
